>>> src/psm_pkg.sv
// shared types and constants of the point-in-shape mask block
package psm_pkg;

  // limbs of the wide accumulator chain, one per factor of the longest product
  localparam int NLIMB       = 6;
  localparam int MUL_STEPS   = 6;
  localparam int NORM_PASSES = NLIMB + 2;
  localparam int STEP_BITS   = 3;

  localparam logic       REQ_LOAD  = 1'b0;
  localparam logic       REQ_TEST  = 1'b1;

  localparam logic       CFG_KIND  = 1'b0;
  localparam logic       CFG_COUNT = 1'b1;

  localparam logic [1:0] KIND_ELL  = 2'd0;
  localparam logic [1:0] KIND_BOX  = 2'd1;
  localparam logic [1:0] KIND_CYL  = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INIT,
    OP_MUL,
    OP_LDADD,
    OP_ADD,
    OP_NORM
  } cell_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SEED,
    ST_MUL,
    ST_ACC,
    ST_NORM,
    ST_DECIDE,
    ST_OUT
  } psm_state_t;

endpackage

>>> src/psm_if.sv
// request and result channel interfaces of the point-in-shape mask block
interface psm_req_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [5:0]                   entry_index;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic [COORD_BITS-2:0]        size_a;
  logic [COORD_BITS-2:0]        size_b;
  logic [COORD_BITS-2:0]        size_c;

  modport source (
    output valid, req_type, entry_index, pos_x, pos_y, pos_z, size_a, size_b, size_c,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, pos_x, pos_y, pos_z, size_a, size_b, size_c,
    output ready
  );
endinterface

interface psm_res_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

>>> src/psm_cell.sv
// one limb cell of the redundant product and accumulator chain
module psm_cell #(
  parameter int LIMB_BITS  = 24,
  parameter int CARRY_BITS = 28
) (
  input  logic                  clk,
  input  psm_pkg::cell_op_t     op,
  input  logic [LIMB_BITS-1:0]  factor,
  input  logic [LIMB_BITS-1:0]  seed,
  input  logic [CARRY_BITS-1:0] prod_cin,
  input  logic [CARRY_BITS-1:0] acc_cin,
  output logic [CARRY_BITS-1:0] prod_cout,
  output logic [CARRY_BITS-1:0] acc_cout,
  output logic [LIMB_BITS-1:0]  acc_limb
);
  localparam int SUM_BITS  = CARRY_BITS + 1;
  localparam int PROD_BITS = SUM_BITS + LIMB_BITS;
  localparam int ACC_BITS  = SUM_BITS + 1;

  logic [LIMB_BITS-1:0]  prod_s;
  logic [CARRY_BITS-1:0] prod_k;
  logic [LIMB_BITS-1:0]  acc_s;
  logic [CARRY_BITS-1:0] acc_k;
  logic [SUM_BITS-1:0]   prod_sum;
  logic [SUM_BITS-1:0]   add_term;
  logic [PROD_BITS-1:0]  prod_full;
  logic [ACC_BITS-1:0]   acc_sum;

  // limb value is s + k; the carry k came from the neighbor below
  assign prod_sum  = SUM_BITS'(prod_s) + SUM_BITS'(prod_k);
  assign prod_full = PROD_BITS'(prod_sum) * PROD_BITS'(factor);
  assign prod_cout = CARRY_BITS'(prod_full >> LIMB_BITS);

  assign add_term  = (op == psm_pkg::OP_LDADD || op == psm_pkg::OP_ADD) ? prod_sum : '0;
  assign acc_sum   = ACC_BITS'(acc_s) + ACC_BITS'(acc_k) + ACC_BITS'(add_term);
  assign acc_cout  = CARRY_BITS'(acc_sum >> LIMB_BITS);
  assign acc_limb  = acc_s;

  always_ff @(posedge clk) begin
    unique case (op)
      psm_pkg::OP_HOLD: begin
      end
      psm_pkg::OP_INIT: begin
        prod_s <= seed;
        prod_k <= '0;
        acc_s  <= '0;
        acc_k  <= '0;
      end
      psm_pkg::OP_MUL: begin
        prod_s <= prod_full[LIMB_BITS-1:0];
        prod_k <= prod_cin;
      end
      psm_pkg::OP_LDADD: begin
        acc_s  <= acc_sum[LIMB_BITS-1:0];
        acc_k  <= acc_cin;
        prod_s <= seed;
        prod_k <= '0;
      end
      psm_pkg::OP_ADD, psm_pkg::OP_NORM: begin
        acc_s <= acc_sum[LIMB_BITS-1:0];
        acc_k <= acc_cin;
      end
      default: begin
      end
    endcase
  end
endmodule

>>> src/psm_shape_mem.sv
// shape entry memory, one write port and one registered read port
module psm_shape_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 141,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

>>> src/point_in_shape_set_mask.sv
// top level: point test against a loadable set of ellipsoids, boxes or cylinders
//
//  channel | dir | handshake          | content
//  --------+-----+--------------------+---------------------------------------------
//  req     | in  | valid/ready        | load of one shape entry, or a point to test
//  res     | out | valid/ready        | inside_res, one item per tested point
//  cfg     | in  | cfg_we, no wait    | index 0 shape kind, index 1 shape count
//
//  a load item is written to the shape memory on acceptance; a test item scans
//  the shapes in order up to and including the first hit (at most the shape
//  count saturated to the table size)
//  each shape runs through the six-limb multiply/accumulate chain: memory read,
//  difference, four six-factor products, accumulate, 8 carry passes
//  the block takes one item at a time; a finished result waits in the output
//  register while the next item is accepted, and the next test holds in its
//  last cycle until that register is free
//  synchronous active-high reset clears control state; the shape memory is not
//  cleared and entries hold garbage until loaded
module point_in_shape_set_mask #(
  parameter int MAX_SHAPES = 64,
  parameter int COORD_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  psm_req_if.sink    req,
  psm_res_if.source  res
);
  localparam int CB     = COORD_BITS;
  localparam int EB     = COORD_BITS - 1;
  localparam int KW     = COORD_BITS + 4;
  localparam int IW     = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int CW     = $clog2(MAX_SHAPES + 1);
  localparam int MEM_W  = 3 * CB + 3 * EB;
  localparam int NLIMB  = psm_pkg::NLIMB;
  localparam int SB     = psm_pkg::STEP_BITS;

  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] p, input logic [CB-1:0] c);
    logic signed [CB:0] d;
    d = $signed({p[CB-1], p}) - $signed({c[CB-1], c});
    return d[CB] ? CB'(-d) : d[CB-1:0];
  endfunction

  psm_pkg::psm_state_t state, state_next;

  // configuration
  logic [1:0]    kind;
  logic [6:0]    count;
  logic [CW-1:0] n_eff;

  // point and the current shape
  logic [CB-1:0] px, py, pz;
  logic [CB-1:0] dx, dy, dz;
  logic [EB-1:0] ea, eb, ec;
  logic [CW-1:0] shp;
  logic [1:0]    term;
  logic [SB-1:0] step;
  logic          hit;
  logic          res_valid;
  logic          res_bit;

  logic             accept;
  logic             mem_we;
  logic [MEM_W-1:0] mem_rdata;
  logic [CB-1:0]    rcx, rcy, rcz;
  logic [EB-1:0]    rea, reb, rec;

  psm_pkg::cell_op_t op;
  logic              seed_neg;
  logic [CB-1:0]     factor;
  logic [CB-1:0]     f_pair, f_q1, f_q2;
  logic              cyl;

  logic [KW-1:0] prod_c [NLIMB];
  logic [KW-1:0] acc_c  [NLIMB];
  logic [CB-1:0] acc_limb [NLIMB];
  logic [CB-1:0] seed [NLIMB];

  logic nonzero, positive, bx, by, bz, in_shape, last, out_free;

  assign accept   = req.valid && req.ready;
  assign out_free = !res_valid || res.ready;
  assign res.valid      = res_valid;
  assign res.inside_res = res_bit;

  always_comb begin
    n_eff = (32'(count) > MAX_SHAPES) ? CW'(MAX_SHAPES) : CW'(count);
  end
  assign last = (shp == n_eff - CW'(1));

  // shape memory: centre and extents of one entry per word
  assign mem_we = accept && (req.req_type == psm_pkg::REQ_LOAD)
                  && (32'(req.entry_index) < MAX_SHAPES);

  psm_shape_mem #(.DEPTH(MAX_SHAPES), .WIDTH(MEM_W), .AW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (IW'(req.entry_index)),
    .wdata ({req.pos_x, req.pos_y, req.pos_z, req.size_a, req.size_b, req.size_c}),
    .raddr (shp[IW-1:0]),
    .rdata (mem_rdata)
  );

  assign {rcx, rcy, rcz, rea, reb, rec} = mem_rdata;

  // factor of the current product step; term 0 is the positive right-hand side
  assign cyl = (kind == psm_pkg::KIND_CYL);

  always_comb begin
    unique case (term)
      2'd0: begin
        f_pair = {1'b0, ea};
        f_q1   = {1'b0, eb};
        f_q2   = {1'b0, ec};
      end
      2'd1: begin
        f_pair = dx;
        f_q1   = {1'b0, eb};
        f_q2   = {1'b0, ec};
      end
      2'd2: begin
        f_pair = dy;
        f_q1   = {1'b0, ea};
        f_q2   = {1'b0, ec};
      end
      default: begin
        // a cylinder has no third squared term
        f_pair = cyl ? '0 : dz;
        f_q1   = {1'b0, ea};
        f_q2   = {1'b0, eb};
      end
    endcase
    if (step < SB'(2)) begin
      factor = f_pair;
    end else if (cyl) begin
      factor = CB'(1);
    end else if (step < SB'(4)) begin
      factor = f_q1;
    end else begin
      factor = f_q2;
    end
  end

  // limb chain: each cell hands its carries to the next one up on every multiply, add or carry pass
  for (genvar i = 0; i < NLIMB; i++) begin : g_cell
    // negative terms start from minus one (all ones), the positive one from one
    assign seed[i] = seed_neg ? '1 : ((i == 0) ? CB'(1) : '0);

    psm_cell #(.LIMB_BITS(CB), .CARRY_BITS(KW)) u_cell (
      .clk       (clk),
      .op        (op),
      .factor    (factor),
      .seed      (seed[i]),
      .prod_cin  ((i == 0) ? '0 : prod_c[(i == 0) ? 0 : i - 1]),
      .acc_cin   ((i == 0) ? '0 : acc_c[(i == 0) ? 0 : i - 1]),
      .prod_cout (prod_c[i]),
      .acc_cout  (acc_c[i]),
      .acc_limb  (acc_limb[i])
    );
  end

  // sign and zero test of the settled accumulator (rhs minus lhs)
  always_comb begin
    nonzero = 1'b0;
    for (int i = 0; i < NLIMB; i++) begin
      nonzero = nonzero | (|acc_limb[i]);
    end
    positive = nonzero && !acc_limb[NLIMB-1][CB-1];
  end

  // box and slab tests on doubled offsets
  assign bx = ({dx, 1'b0} < (CB + 1)'(ea));
  assign by = ({dy, 1'b0} < (CB + 1)'(eb));
  assign bz = ({dz, 1'b0} < (CB + 1)'(ec));

  always_comb begin
    unique case (kind)
      psm_pkg::KIND_ELL: in_shape = (ea != '0) && (eb != '0) && (ec != '0) && positive;
      psm_pkg::KIND_BOX: in_shape = bx && by && bz;
      psm_pkg::KIND_CYL: in_shape = bz && positive;
      default:           in_shape = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    op         = psm_pkg::OP_HOLD;
    seed_neg   = 1'b0;
    req.ready  = 1'b0;
    unique case (state)
      psm_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid && req.req_type == psm_pkg::REQ_TEST) begin
          state_next = (n_eff == '0) ? psm_pkg::ST_OUT : psm_pkg::ST_READ;
        end
      end
      psm_pkg::ST_READ: state_next = psm_pkg::ST_DIFF;
      psm_pkg::ST_DIFF: state_next = psm_pkg::ST_SEED;
      psm_pkg::ST_SEED: begin
        op         = psm_pkg::OP_INIT;
        state_next = psm_pkg::ST_MUL;
      end
      psm_pkg::ST_MUL: begin
        op = psm_pkg::OP_MUL;
        if (step == SB'(psm_pkg::MUL_STEPS - 1)) begin
          state_next = psm_pkg::ST_ACC;
        end
      end
      psm_pkg::ST_ACC: begin
        seed_neg = 1'b1;
        if (term == 2'd3) begin
          op         = psm_pkg::OP_ADD;
          state_next = psm_pkg::ST_NORM;
        end else begin
          op         = psm_pkg::OP_LDADD;
          state_next = psm_pkg::ST_MUL;
        end
      end
      psm_pkg::ST_NORM: begin
        op = psm_pkg::OP_NORM;
        if (step == SB'(psm_pkg::NORM_PASSES - 1)) begin
          state_next = psm_pkg::ST_DECIDE;
        end
      end
      psm_pkg::ST_DECIDE: begin
        state_next = (in_shape || last) ? psm_pkg::ST_OUT : psm_pkg::ST_READ;
      end
      psm_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = psm_pkg::ST_IDLE;
        end
      end
      default: state_next = psm_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= psm_pkg::ST_IDLE;
      kind      <= psm_pkg::KIND_ELL;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          psm_pkg::CFG_KIND:  kind  <= cfg_data[1:0];
          psm_pkg::CFG_COUNT: count <= cfg_data;
          default: begin
          end
        endcase
      end
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      if (state == psm_pkg::ST_OUT && out_free) begin
        res_valid <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == psm_pkg::ST_IDLE && accept) begin
      px   <= req.pos_x;
      py   <= req.pos_y;
      pz   <= req.pos_z;
      shp  <= '0;
      hit  <= 1'b0;
    end
    if (state == psm_pkg::ST_DIFF) begin
      dx   <= abs_diff(px, rcx);
      dy   <= abs_diff(py, rcy);
      dz   <= abs_diff(pz, rcz);
      ea   <= rea;
      eb   <= reb;
      ec   <= rec;
      term <= 2'd0;
      step <= '0;
    end
    if (state == psm_pkg::ST_MUL) begin
      step <= (step == SB'(psm_pkg::MUL_STEPS - 1)) ? '0 : step + SB'(1);
    end
    if (state == psm_pkg::ST_ACC) begin
      step <= '0;
      term <= term + 2'd1;
    end
    if (state == psm_pkg::ST_NORM) begin
      step <= step + SB'(1);
    end
    if (state == psm_pkg::ST_DECIDE) begin
      hit <= in_shape;
      shp <= shp + CW'(1);
    end
    if (state == psm_pkg::ST_OUT && out_free) begin
      res_bit <= hit;
    end
  end
endmodule

>>> tb/sv/point_in_shape_set_mask_tb.sv
// self-checking testbench of the point-in-shape mask block
`timescale 1ns / 100ps

module point_in_shape_set_mask_tb;

  localparam int NSHAPE    = 64;
  localparam int CBITS     = 24;
  localparam int DRAIN_CYC = 60;          // settle time before a register write
  localparam int CYC_LIMIT = 10_000_000;  // watchdog bound on the total run length, stalls included

  typedef logic signed [CBITS-1:0] pos_t;
  typedef logic [CBITS-2:0]        ext_t;

  typedef struct {
    logic       req_type;
    logic [5:0] entry_index;
    pos_t       pos_x, pos_y, pos_z;
    ext_t       size_a, size_b, size_c;
  } shape_req_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [6:0] cfg_data;

  psm_req_if #(.COORD_BITS(CBITS)) req_ch ();
  psm_res_if                        res_ch ();

  point_in_shape_set_mask #(.MAX_SHAPES(NSHAPE), .COORD_BITS(CBITS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  // pending items for the driver, expected inside bits for the monitor
  shape_req_t pending_q[$];
  bit         inside_q[$];
  int         err_cnt  = 0;
  int         acc_cnt  = 0;
  int         cyc_cnt  = 0;

  // shadow copy of the shape table and the two registers
  pos_t       cen_x[NSHAPE], cen_y[NSHAPE], cen_z[NSHAPE];
  ext_t       ext_a[NSHAPE], ext_b[NSHAPE], ext_c[NSHAPE];
  logic [1:0] kind_reg  = psm_pkg::KIND_ELL;
  logic [6:0] count_reg = '0;

  // generator-side view of which entries are loaded, so no test reads garbage
  bit         loaded[NSHAPE];

  // a calm stretch in the middle of the run: no idling on either side
  wire calm = (acc_cnt >= 300) && (acc_cnt < 550);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact shape test, all products kept at full width
  function automatic bit covers(int k, pos_t px, pos_t py, pos_t pz);
    logic [191:0] dx, dy, dz, a, b, c, lhs, rhs;
    int           d;
    d  = int'(px) - int'(cen_x[k]);
    dx = (d < 0) ? -d : d;
    d  = int'(py) - int'(cen_y[k]);
    dy = (d < 0) ? -d : d;
    d  = int'(pz) - int'(cen_z[k]);
    dz = (d < 0) ? -d : d;
    a  = ext_a[k];
    b  = ext_b[k];
    c  = ext_c[k];
    case (kind_reg)
      psm_pkg::KIND_ELL: begin
        if (a == 0 || b == 0 || c == 0) return 1'b0;
        lhs = dx*dx*b*b*c*c + dy*dy*a*a*c*c + dz*dz*a*a*b*b;
        rhs = a*a*b*b*c*c;
        return lhs < rhs;
      end
      psm_pkg::KIND_BOX: return (2*dx < a) && (2*dy < b) && (2*dz < c);
      psm_pkg::KIND_CYL: begin
        if (!(2*dz < c)) return 1'b0;
        return dx*dx + dy*dy < a*a;
      end
      default: return 1'b0;  // unused kind matches nothing
    endcase
  endfunction

  // update the shadow table on a load, or queue the expected bit of a test
  task automatic predict_inside(shape_req_t it);
    int n;
    bit hit;
    if (it.req_type == psm_pkg::REQ_LOAD) begin
      cen_x[it.entry_index] = it.pos_x;
      cen_y[it.entry_index] = it.pos_y;
      cen_z[it.entry_index] = it.pos_z;
      ext_a[it.entry_index] = it.size_a;
      ext_b[it.entry_index] = it.size_b;
      ext_c[it.entry_index] = it.size_c;
    end else begin
      // count saturates at the table size
      n   = (count_reg > NSHAPE) ? NSHAPE : int'(count_reg);
      hit = 1'b0;
      for (int k = 0; k < n && !hit; k++) hit = covers(k, it.pos_x, it.pos_y, it.pos_z);
      inside_q = {inside_q, hit};
    end
  endtask

  // driver: predict on acceptance, then present the next item or idle
  always @(posedge clk) begin
    shape_req_t nxt;
    bit         idle;
    if (rst) begin
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= psm_pkg::REQ_LOAD;
      req_ch.entry_index <= '0;
      req_ch.pos_x       <= '0;
      req_ch.pos_y       <= '0;
      req_ch.pos_z       <= '0;
      req_ch.size_a      <= '0;
      req_ch.size_b      <= '0;
      req_ch.size_c      <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_inside('{req_ch.req_type, req_ch.entry_index, req_ch.pos_x, req_ch.pos_y,
                         req_ch.pos_z, req_ch.size_a, req_ch.size_b, req_ch.size_c});
        acc_cnt++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        idle = !calm && ($urandom_range(0, 99) < 12);
        if (!idle && pending_q.size() > 0) begin
          nxt                 = pending_q.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.req_type    <= nxt.req_type;
          req_ch.entry_index <= nxt.entry_index;
          req_ch.pos_x       <= nxt.pos_x;
          req_ch.pos_y       <= nxt.pos_y;
          req_ch.pos_z       <= nxt.pos_z;
          req_ch.size_a      <= nxt.size_a;
          req_ch.size_b      <= nxt.size_b;
          req_ch.size_c      <= nxt.size_c;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    bit exp_bit;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (inside_q.size() == 0) begin
          $error("unexpected result item: inside_res=%0b", res_ch.inside_res);
          err_cnt++;
        end else begin
          exp_bit = inside_q.pop_front();
          if (res_ch.inside_res !== exp_bit) begin
            $error("inside_res mismatch: expected %0b, actual %0b", exp_bit,
                   res_ch.inside_res);
            err_cnt++;
          end
        end
      end
      res_ch.ready <= calm || ($urandom_range(0, 99) >= 12);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYC_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_load(int idx, pos_t x, pos_t y, pos_t z, ext_t a, ext_t b, ext_t c);
    shape_req_t it;
    it        = '{psm_pkg::REQ_LOAD, 6'(idx), x, y, z, a, b, c};
    pending_q = {pending_q, it};
    loaded[idx] = 1'b1;
  endtask

  task automatic push_test(pos_t x, pos_t y, pos_t z);
    ext_t       junk_a, junk_b, junk_c;
    shape_req_t it;
    junk_a = ext_t'($urandom);
    junk_b = ext_t'($urandom);
    junk_c = ext_t'($urandom);
    // entry_index and sizes are don't-care for a test: randomize them
    it        = '{psm_pkg::REQ_TEST, 6'($urandom), x, y, z, junk_a, junk_b, junk_c};
    pending_q = {pending_q, it};
  endtask

  // wait until every item is sent and every result is back, then let loads settle
  task automatic drain;
    while (pending_q.size() > 0 || req_ch.valid || inside_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic write_reg(logic idx, int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 7'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == psm_pkg::CFG_KIND) kind_reg = 2'(value);
    else count_reg = 7'(value);
  endtask

  function automatic ext_t rand_ext();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ext_t'($urandom);
      default: return ext_t'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic pos_t rand_pos();
    if ($urandom_range(0, 3) == 0) return pos_t'($urandom);
    return pos_t'(int'($urandom_range(0, 40000)) - 20000);
  endfunction

  function automatic pos_t near(pos_t ctr, ext_t ext);
    int span;
    span = int'(ext) + 2;
    return pos_t'(int'(ctr) + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic bit prefix_loaded(int n);
    for (int k = 0; k < n; k++) if (!loaded[k]) return 1'b0;
    return 1'b1;
  endfunction

  initial begin
    int   n, eff, k, kind, ntests;
    pos_t pmax, pmin;
    pmax = {1'b0, {(CBITS-1){1'b1}}};
    pmin = {1'b1, {(CBITS-1){1'b0}}};

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = psm_pkg::CFG_KIND;
    cfg_data           = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: count zero answers 0 even with nothing loaded
    push_test(0, 0, 0);
    // unit-ish shape at the origin, points on and just inside each boundary
    push_load(0, 0, 0, 0, 256, 256, 256);
    write_reg(psm_pkg::CFG_COUNT, 1);
    push_test(0, 0, 0);
    push_test(255, 0, 0);
    push_test(256, 0, 0);
    write_reg(psm_pkg::CFG_KIND, psm_pkg::KIND_BOX);
    push_test(127, 0, -127);
    push_test(128, 0, 0);
    write_reg(psm_pkg::CFG_KIND, psm_pkg::KIND_CYL);
    push_test(200, 150, 0);
    push_test(0, 0, 128);
    push_test(0, 0, 127);
    // extreme centre and extents, far-apart points
    push_load(0, pmax, pmin, 0, '1, '1, '1);
    push_test(pmin, pmax, 0);
    push_test(pmax, pmin, pmax);
    write_reg(psm_pkg::CFG_KIND, psm_pkg::KIND_ELL);
    push_test(pmax, pmin, 0);
    push_test(pmin, pmax, pmin);
    // a zero extent never contains a point
    push_load(0, 0, 0, 0, 0, 1000, 1000);
    push_test(0, 0, 0);
    write_reg(psm_pkg::CFG_KIND, psm_pkg::KIND_BOX);
    push_test(0, 0, 0);
    // unused kind matches nothing
    push_load(0, 0, 0, 0, 1000, 1000, 1000);
    write_reg(psm_pkg::CFG_KIND, 3);
    push_test(0, 0, 0);

    // fill the whole table, then a count above the table size saturates
    for (k = 0; k < NSHAPE; k++) push_load(k, rand_pos(), rand_pos(), rand_pos(),
                                           rand_ext(), rand_ext(), rand_ext());
    write_reg(psm_pkg::CFG_KIND, psm_pkg::KIND_ELL);
    write_reg(psm_pkg::CFG_COUNT, 127);
    for (k = 0; k < 4; k++) push_test(near(cen_x[k], ext_a[k]), rand_pos(), rand_pos());
    write_reg(psm_pkg::CFG_COUNT, NSHAPE);
    push_test(rand_pos(), rand_pos(), rand_pos());

    // random phases: reload a few entries, set kind and count, stream tests
    while (acc_cnt < 1000) begin
      kind = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
      n    = ($urandom_range(0, 15) == 0) ? $urandom_range(1, NSHAPE) : $urandom_range(0, 6);
      for (k = 0; k < n && k < 8; k++)
        push_load(k, rand_pos(), rand_pos(), rand_pos(), rand_ext(), rand_ext(), rand_ext());
      // noise loads anywhere, full-range fields
      if ($urandom_range(0, 2) == 0)
        push_load($urandom_range(0, NSHAPE - 1), pos_t'($urandom), pos_t'($urandom),
                  pos_t'($urandom), ext_t'($urandom), ext_t'($urandom), ext_t'($urandom));
      write_reg(psm_pkg::CFG_KIND, kind);
      write_reg(psm_pkg::CFG_COUNT, n);
      drain();  // sender holds off until every result is back
      eff    = (n > NSHAPE) ? NSHAPE : n;
      ntests = (n > 16) ? 4 : 20;
      if (prefix_loaded(eff)) begin
        for (int t = 0; t < ntests; t++) begin
          if (eff > 0 && $urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, eff - 1);
            push_test(near(cen_x[k], ext_a[k]), near(cen_y[k], ext_b[k]),
                      near(cen_z[k], ext_c[k]));
          end else begin
            push_test(pos_t'($urandom), pos_t'($urandom), pos_t'($urandom));
          end
        end
      end
    end

    drain();
    if (inside_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/psm_pkg.sv
src/psm_if.sv
src/psm_cell.sv
src/psm_shape_mem.sv
src/point_in_shape_set_mask.sv
tb/sv/point_in_shape_set_mask_tb.sv
